// ----- hdl/ljpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared types and constants of the Lennard-Jones pair force pipeline.
// ----------------------------------------------------------------------------
package ljpf_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_BOX_LENGTH    = 2'd0;
    localparam logic [1:0] REG_TIME_STEP     = 2'd1;
    localparam logic [1:0] REG_SIGMA_LEN     = 2'd2;
    localparam logic [1:0] REG_EPSILON_DEPTH = 2'd3;

    localparam int CFG_W   = 25;   // widest register
    localparam int POS_W   = 24;
    localparam int OUT_W   = 32;
    localparam int WIDE_W  = 64;   // working width of the force chain
    localparam int R2_W    = 50;   // squared distance, three 48-bit squares
    localparam int ROOT_W  = 25;   // floor(sqrt(r2))
    localparam int MUL_LAT = 3;    // latency of the multiply-shift unit

    typedef struct packed {
        logic [POS_W-1:0] pos_a_x;
        logic [POS_W-1:0] pos_a_y;
        logic [POS_W-1:0] pos_a_z;
        logic [POS_W-1:0] pos_b_x;
        logic [POS_W-1:0] pos_b_y;
        logic [POS_W-1:0] pos_b_z;
    } pos_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] dvel_x;
        logic signed [OUT_W-1:0] dvel_y;
        logic signed [OUT_W-1:0] dvel_z;
        logic signed [OUT_W-1:0] pair_energy;
        logic                    zero_distance;
    } res_t;

endpackage

// ----- hdl/ljpf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_div
// Pipelined restoring divider: one quotient bit per stage, NUM_W stages.
// ----------------------------------------------------------------------------
module ljpf_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 25
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] work_reg [NUM_W];
    logic [NUM_W-1:0] work_next [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [DEN_W-1:0] rem_next [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [DEN_W-1:0] den_next [NUM_W];

    // Shift one numerator bit into the remainder, subtract when it fits
    always_comb
    begin
        logic [NUM_W-1:0] w_in;
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W:0]   shifted;
        for (int s = 0; s < NUM_W; s++)
        begin
            w_in = (s == 0) ? num : work_reg[(s == 0) ? 0 : s-1];
            r_in = (s == 0) ? '0  : rem_reg[(s == 0) ? 0 : s-1];
            d_in = (s == 0) ? den : den_reg[(s == 0) ? 0 : s-1];
            shifted = {r_in, w_in[NUM_W-1]};
            den_next[s] = d_in;
            if (shifted >= {1'b0, d_in})
            begin
                rem_next[s]  = DEN_W'(shifted - {1'b0, d_in});
                work_next[s] = {w_in[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = shifted[DEN_W-1:0];
                work_next[s] = {w_in[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Advance every stage each cycle
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NUM_W; s++)
        begin
            work_reg[s] <= work_next[s];
            rem_reg[s]  <= rem_next[s];
            den_reg[s]  <= den_next[s];
        end
    end

    assign quo = work_reg[NUM_W-1];

endmodule

// ----- hdl/ljpf_mulsh.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_mulsh
// 64 x 64 multiply, shift right by SH, saturate to 64 bits; three stages.
// ----------------------------------------------------------------------------
module ljpf_mulsh #(
    parameter int SH = 32
) (
    input  logic                        clk,
    input  logic [ljpf_pkg::WIDE_W-1:0] a,
    input  logic [ljpf_pkg::WIDE_W-1:0] b,
    output logic [ljpf_pkg::WIDE_W-1:0] y
);

    localparam int W  = ljpf_pkg::WIDE_W;
    localparam int HW = W / 2;

    logic [W-1:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic [2*W-1:0] prod_reg;
    logic [W-1:0]   y_reg;

    // Partial products of the 32-bit halves
    always_ff @(posedge clk)
    begin
        ll_reg <= W'(a[HW-1:0]) * W'(b[HW-1:0]);
        lh_reg <= W'(a[HW-1:0]) * W'(b[W-1:HW]);
        hl_reg <= W'(a[W-1:HW]) * W'(b[HW-1:0]);
        hh_reg <= W'(a[W-1:HW]) * W'(b[W-1:HW]);
    end

    // Sum into the full product
    always_ff @(posedge clk)
    begin
        prod_reg <= (2*W)'(ll_reg) + ((2*W)'(lh_reg) << HW) + ((2*W)'(hl_reg) << HW)
                    + ((2*W)'(hh_reg) << W);
    end

    // Shift and clamp
    always_ff @(posedge clk)
    begin
        if (|prod_reg[2*W-1:W+SH])
            y_reg <= '1;
        else
            y_reg <= prod_reg[W+SH-1:SH];
    end

    assign y = y_reg;

endmodule

// ----- hdl/lj_pair_force_min_image_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_pair_force_min_image_top
// Lennard-Jones pair force and energy with minimum-image displacement.
//
// Usage: drive the two particle positions on pos and raise start; the item is
// taken at every rising edge where start is high and busy is low. busy stays
// low, so a new pair may enter in every cycle. Each item yields one result on
// res, shown for exactly one cycle with done high; results leave in the order
// the pairs came in. The pipeline is built from these stages: minimum image,
// squares and sum (3), the bit-serial square root (25 stages), the
// one-bit-per-stage dividers for sigma/r, 1/r and the direction cosines
// (64 stages), and the chain of eight three-stage multipliers plus the
// force/energy select stage and the output register (26). The receiver cannot
// stall, so the pipeline advances every cycle. The user must write registers
// through wr_en/wr_idx/wr_data only while no item is in flight; the block does
// not enforce it. Reset clears the valid bits and the output strobe and loads
// the register defaults (box 15.0, time step ~0.001, sigma 1.5, epsilon 1.0).
// ----------------------------------------------------------------------------
module lj_pair_force_min_image_top #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ljpf_pkg::pos_t             pos,
    output logic                       done,
    output ljpf_pkg::res_t             res,
    input  logic                       wr_en,
    input  logic [1:0]                 wr_idx,
    input  logic [ljpf_pkg::CFG_W-1:0] wr_data
);

    localparam int PW    = ljpf_pkg::POS_W;
    localparam int W     = ljpf_pkg::WIDE_W;
    localparam int M     = ljpf_pkg::MUL_LAT;
    localparam int RW    = ljpf_pkg::ROOT_W;
    localparam int R2W   = ljpf_pkg::R2_W;
    localparam int OW    = ljpf_pkg::OUT_W;
    localparam int T_R2  = 3;
    localparam int T_DIV = T_R2 + RW + W;
    localparam int T_G   = T_DIV + 4*M + 1;
    localparam int T_M   = T_G + 4*M;
    localparam int D_INV = 5*M + 1;
    localparam int D_COS = 7*M + 1;
    localparam int D_TAG = T_M - T_R2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PW-1:0] box_reg, sigma_reg, eps_reg;
    logic [PW:0]   tstep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg   <= PW'(983040);
            tstep_reg <= (PW+1)'(16777);
            sigma_reg <= PW'(98304);
            eps_reg   <= PW'(65536);
        end
        else if (wr_en)
        begin
            case (wr_idx)
                ljpf_pkg::REG_BOX_LENGTH:    box_reg   <= wr_data[PW-1:0];
                ljpf_pkg::REG_TIME_STEP:     tstep_reg <= wr_data;
                ljpf_pkg::REG_SIGMA_LEN:     sigma_reg <= wr_data[PW-1:0];
                ljpf_pkg::REG_EPSILON_DEPTH: eps_reg   <= wr_data[PW-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    logic [T_M-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[T_M-2:0], accept};
    end

    // ------------------------------------------------------------------
    // Stage 1: minimum-image displacement per axis
    // ------------------------------------------------------------------
    logic [PW-1:0] pa [3];
    logic [PW-1:0] pb [3];
    logic [PW-1:0] dabs_next [3];
    logic [2:0]    dneg_next;
    logic [PW-1:0] dabs_reg [3];
    logic [2:0]    dneg_reg;

    assign pa[0] = pos.pos_a_x;
    assign pa[1] = pos.pos_a_y;
    assign pa[2] = pos.pos_a_z;
    assign pb[0] = pos.pos_b_x;
    assign pb[1] = pos.pos_b_y;
    assign pb[2] = pos.pos_b_z;

    always_comb
    begin
        logic signed [PW+2:0] base;
        logic signed [PW+2:0] opt [3];
        logic        [PW+2:0] mag [3];
        logic        [1:0]    pick;
        for (int i = 0; i < 3; i++)
        begin
            base   = $signed({3'b000, pb[i]}) - $signed({3'b000, pa[i]});
            opt[0] = base + $signed({3'b000, box_reg});
            opt[1] = base;
            opt[2] = base - $signed({3'b000, box_reg});
            for (int k = 0; k < 3; k++)
                mag[k] = opt[k][PW+2] ? (PW+3)'(-opt[k]) : opt[k];
            pick = 2'd0;
            if (mag[0] > mag[1])
                pick = 2'd1;
            if (mag[pick] > mag[2])
                pick = 2'd2;
            dabs_next[i] = mag[pick][PW-1:0];
            dneg_next[i] = opt[pick][PW+2];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            dabs_reg[i] <= dabs_next[i];
        dneg_reg <= dneg_next;
    end

    // ------------------------------------------------------------------
    // Stages 2-3: squares, then their sum
    // ------------------------------------------------------------------
    logic [2*PW-1:0] sq_reg [3];
    logic [PW-1:0]   dabs2_reg [3];
    logic [PW-1:0]   dabs3_reg [3];
    logic [2:0]      dneg2_reg, dneg3_reg;
    logic [R2W-1:0]  r2_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i]    <= (2*PW)'(dabs_reg[i]) * (2*PW)'(dabs_reg[i]);
            dabs2_reg[i] <= dabs_reg[i];
            dabs3_reg[i] <= dabs2_reg[i];
        end
        dneg2_reg <= dneg_reg;
        dneg3_reg <= dneg2_reg;
        r2_reg    <= R2W'(sq_reg[0]) + R2W'(sq_reg[1]) + R2W'(sq_reg[2]);
    end

    // Hold zero flag and displacement signs until the output stage
    logic [D_TAG-1:0][3:0] tag_reg;

    always_ff @(posedge clk)
    begin
        tag_reg <= {tag_reg[D_TAG-2:0], {(r2_reg == '0), dneg3_reg}};
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage
    // ------------------------------------------------------------------
    logic [R2W-1:0] rt_rem_reg [RW];
    logic [R2W-1:0] rt_rem_next [RW];
    logic [RW-1:0]  rt_root_reg [RW];
    logic [RW-1:0]  rt_root_next [RW];

    always_comb
    begin
        logic [R2W-1:0] rin;
        logic [RW-1:0]  oin;
        logic [R2W-1:0] inc;
        for (int s = 0; s < RW; s++)
        begin
            rin = (s == 0) ? r2_reg : rt_rem_reg[(s == 0) ? 0 : s-1];
            oin = (s == 0) ? '0     : rt_root_reg[(s == 0) ? 0 : s-1];
            inc = (R2W'(oin) << (RW - s)) | (R2W'(1) << (2*(RW-1-s)));
            if (rin >= inc)
            begin
                rt_rem_next[s]  = rin - inc;
                rt_root_next[s] = oin | (RW'(1) << (RW-1-s));
            end
            else
            begin
                rt_rem_next[s]  = rin;
                rt_root_next[s] = oin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < RW; s++)
        begin
            rt_rem_reg[s]  <= rt_rem_next[s];
            rt_root_reg[s] <= rt_root_next[s];
        end
    end

    logic [RW-1:0] root;
    assign root = rt_root_reg[RW-1];

    // Delay the displacement magnitudes to meet the root
    logic [RW-1:0][3*PW-1:0] dabs_dly_reg;

    always_ff @(posedge clk)
    begin
        dabs_dly_reg <= {dabs_dly_reg[RW-2:0], {dabs3_reg[0], dabs3_reg[1], dabs3_reg[2]}};
    end

    logic [3*PW-1:0] dabs_r;
    assign dabs_r = dabs_dly_reg[RW-1];

    // ------------------------------------------------------------------
    // Dividers: sigma/r, 1/r and the three direction cosines
    // ------------------------------------------------------------------
    logic [W-1:0] q, inv;
    logic [W-1:0] cosd [3];

    ljpf_div #(.NUM_W(W), .DEN_W(RW)) u_div_q (
        .clk (clk),
        .num ({8'd0, sigma_reg, 32'd0}),
        .den (root),
        .quo (q)
    );

    ljpf_div #(.NUM_W(W), .DEN_W(RW)) u_div_inv (
        .clk (clk),
        .num (W'(1) << (32 + POS_FRAC_BITS)),
        .den (root),
        .quo (inv)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_cos
        ljpf_div #(.NUM_W(W), .DEN_W(RW)) u_div_cos (
            .clk (clk),
            .num ({8'd0, dabs_r[(2-i)*PW +: PW], 32'd0}),
            .den (root),
            .quo (cosd[i])
        );
    end

    // ------------------------------------------------------------------
    // Powers of sigma/r
    // ------------------------------------------------------------------
    logic [W-1:0] q2, q4, q6, q12;
    logic [M-1:0][W-1:0] q2_dly_reg, q6_dly_reg;

    ljpf_mulsh #(.SH(32)) u_mul_q2 (.clk(clk), .a(q), .b(q), .y(q2));
    ljpf_mulsh #(.SH(32)) u_mul_q4 (.clk(clk), .a(q2), .b(q2), .y(q4));
    ljpf_mulsh #(.SH(32)) u_mul_q6 (.clk(clk), .a(q2_dly_reg[M-1]), .b(q4), .y(q6));
    ljpf_mulsh #(.SH(32)) u_mul_q12 (.clk(clk), .a(q6), .b(q6), .y(q12));

    always_ff @(posedge clk)
    begin
        q2_dly_reg <= {q2_dly_reg[M-2:0], q2};
        q6_dly_reg <= {q6_dly_reg[M-2:0], q6};
    end

    // ------------------------------------------------------------------
    // Force and energy terms, magnitude and sign
    // ------------------------------------------------------------------
    logic [W-1:0] gmag_reg, emag_reg;
    logic         gneg_reg, eneg_reg;

    always_ff @(posedge clk)
    begin
        logic [W-1:0] q6d;
        logic [W-1:0] twice;
        q6d   = q6_dly_reg[M-1];
        twice = q12[W-1] ? '1 : {q12[W-2:0], 1'b0};
        if (q12 == '1)
        begin
            gmag_reg <= '1;
            gneg_reg <= 1'b1;
            emag_reg <= '1;
            eneg_reg <= 1'b0;
        end
        else
        begin
            if (q6d >= twice)
            begin
                gmag_reg <= q6d - twice;
                gneg_reg <= 1'b0;
            end
            else
            begin
                gmag_reg <= twice - q6d;
                gneg_reg <= 1'b1;
            end
            if (q12 >= q6d)
            begin
                emag_reg <= q12 - q6d;
                eneg_reg <= 1'b0;
            end
            else
            begin
                emag_reg <= q6d - q12;
                eneg_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale by epsilon, 1/r, time step and direction cosine
    // ------------------------------------------------------------------
    logic [W-1:0] hval, fval, pval, energy;
    logic [W-1:0] mval [3];
    logic [D_INV-1:0][W-1:0]   inv_dly_reg;
    logic [D_COS-1:0][3*W-1:0] cos_dly_reg;
    logic [3*M-1:0][W-1:0]     en_dly_reg;
    logic [4*M-1:0][1:0]       sgn_dly_reg;

    ljpf_mulsh #(.SH(16)) u_mul_h (
        .clk (clk), .a(W'(eps_reg) * W'(24)), .b(gmag_reg), .y(hval)
    );
    ljpf_mulsh #(.SH(32)) u_mul_en (
        .clk (clk), .a(W'(eps_reg) * W'(8)), .b(emag_reg), .y(energy)
    );
    ljpf_mulsh #(.SH(32)) u_mul_f (
        .clk (clk), .a(hval), .b(inv_dly_reg[D_INV-1]), .y(fval)
    );
    ljpf_mulsh #(.SH(24)) u_mul_p (
        .clk (clk), .a(fval), .b(W'(tstep_reg)), .y(pval)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_dv
        ljpf_mulsh #(.SH(40)) u_mul_m (
            .clk (clk),
            .a   (pval),
            .b   (cos_dly_reg[D_COS-1][(2-i)*W +: W]),
            .y   (mval[i])
        );
    end

    always_ff @(posedge clk)
    begin
        inv_dly_reg <= {inv_dly_reg[D_INV-2:0], inv};
        cos_dly_reg <= {cos_dly_reg[D_COS-2:0], {cosd[0], cosd[1], cosd[2]}};
        en_dly_reg  <= {en_dly_reg[3*M-2:0], energy};
        sgn_dly_reg <= {sgn_dly_reg[4*M-2:0], {gneg_reg, eneg_reg}};
    end

    // ------------------------------------------------------------------
    // Output stage: signs, saturation, zero-distance override
    // ------------------------------------------------------------------
    function automatic logic [OW-1:0] sat32(input logic [W-1:0] mag, input logic neg);
        logic [OW-1:0] m;
        if (neg)
        begin
            m = (mag > W'(64'h8000_0000)) ? 32'h8000_0000 : mag[OW-1:0];
            return OW'(-m);
        end
        m = (mag > W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[OW-1:0];
        return m;
    endfunction

    logic [3:0]     tag_out;
    logic           gneg_out, eneg_out;
    ljpf_pkg::res_t res_next;
    ljpf_pkg::res_t res_reg;
    logic           done_reg;

    assign tag_out  = tag_reg[D_TAG-1];
    assign gneg_out = sgn_dly_reg[4*M-1][1];
    assign eneg_out = sgn_dly_reg[4*M-1][0];

    // Axis signs sit at tag bits 0 (x), 1 (y) and 2 (z)
    always_comb
    begin
        if (tag_out[3])
        begin
            res_next               = '0;
            res_next.zero_distance = 1'b1;
        end
        else
        begin
            res_next.dvel_x        = sat32(mval[0], gneg_out ^ tag_out[0]);
            res_next.dvel_y        = sat32(mval[1], gneg_out ^ tag_out[1]);
            res_next.dvel_z        = sat32(mval[2], gneg_out ^ tag_out[2]);
            res_next.pair_energy   = sat32(en_dly_reg[3*M-1], eneg_out);
            res_next.zero_distance = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[T_M-1];
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule
